@@ rtl/dcc_pf_pkg.sv @@
`timescale 1ns / 1ps

package dcc_pf_pkg;

  // Request codes
  localparam logic [1:0] REQ_THROTTLE = 2'd0;
  localparam logic [1:0] REQ_IDLE     = 2'd1;
  localparam logic [1:0] REQ_RESET    = 2'd2;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TRACK_POWER   = 3'd0;
  localparam logic [2:0] REG_ONE_PERIOD    = 3'd1;
  localparam logic [2:0] REG_ZERO_PERIOD   = 3'd2;
  localparam logic [2:0] REG_PREAMBLE_BITS = 3'd3;
  localparam logic [2:0] REG_CLOSER_BITS   = 3'd4;

  localparam int unsigned ADDR_W = 5;

  // Reset values
  localparam logic [15:0] ONE_PERIOD_RST    = 16'd58;
  localparam logic [15:0] ZERO_PERIOD_RST   = 16'd100;
  localparam logic [4:0]  PREAMBLE_BITS_RST = 5'd14;
  localparam logic [2:0]  CLOSER_BITS_RST   = 3'd1;

  // Framing limits
  localparam logic [4:0] PRE_MIN   = 5'd10;
  localparam logic [4:0] PRE_MAX   = 5'd20;
  localparam logic [2:0] CLOSE_MIN = 3'd1;
  localparam logic [2:0] CLOSE_MAX = 3'd4;

  // Byte constants
  localparam logic [7:0]  CMD_BASE      = 8'h40;
  localparam logic [7:0]  LONG_ADDR_TAG = 8'hC0;
  localparam logic [7:0]  BYTE_ONES     = 8'hFF;
  localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] cab_address;
    logic [4:0]  speed_step;
    logic        direction;
  } dcc_req_t;

  typedef struct packed {
    logic        bit_value;
    logic [15:0] period;
    logic        last;
  } dcc_sym_t;

  typedef struct packed {
    logic        track_power;
    logic [15:0] one_period;
    logic [15:0] zero_period;
    logic [4:0]  preamble_bits;
    logic [2:0]  closer_bits;
  } dcc_cfg_t;

  // Packet bytes, first byte in [31:24], error byte included
  typedef struct packed {
    logic        emit;
    logic [31:0] bytes;
    logic [2:0]  nbytes;
  } dcc_frame_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_BYTE,
    ST_CLOSE
  } dcc_state_t;

endpackage

@@ rtl/dcc_pf_regs.sv @@
`timescale 1ns / 1ps

module dcc_pf_regs
  import dcc_pf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dcc_cfg_t          cfg
);

  dcc_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_power   <= 1'b0;
      cfg_r.one_period    <= ONE_PERIOD_RST;
      cfg_r.zero_period   <= ZERO_PERIOD_RST;
      cfg_r.preamble_bits <= PREAMBLE_BITS_RST;
      cfg_r.closer_bits   <= CLOSER_BITS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRACK_POWER:   cfg_r.track_power   <= pwdata[0];
        REG_ONE_PERIOD:    cfg_r.one_period    <= pwdata[15:0];
        REG_ZERO_PERIOD:   cfg_r.zero_period   <= pwdata[15:0];
        REG_PREAMBLE_BITS: cfg_r.preamble_bits <= pwdata[4:0];
        REG_CLOSER_BITS:   cfg_r.closer_bits   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRACK_POWER:   prdata = {31'd0, cfg_r.track_power};
      REG_ONE_PERIOD:    prdata = {16'd0, cfg_r.one_period};
      REG_ZERO_PERIOD:   prdata = {16'd0, cfg_r.zero_period};
      REG_PREAMBLE_BITS: prdata = {27'd0, cfg_r.preamble_bits};
      REG_CLOSER_BITS:   prdata = {29'd0, cfg_r.closer_bits};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/dcc_pf_bytes.sv @@
`timescale 1ns / 1ps

module dcc_pf_bytes
  import dcc_pf_pkg::*;
(
  input  dcc_req_t   req,
  input  logic       track_power,
  output dcc_frame_t frame
);

  logic [7:0] cmd;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] err;
  logic       long_form;

  assign cmd       = CMD_BASE | {2'b00, req.direction, req.speed_step};
  assign hi        = {2'b00, req.cab_address[13:8]} | LONG_ADDR_TAG;
  assign lo        = req.cab_address[7:0];
  assign long_form = req.cab_address > SHORT_ADDR_MAX;

  always_comb begin
    frame.emit = track_power && (req.req_type != REQ_UNUSED);
    err        = 8'd0;
    unique case (req.req_type)
      REQ_THROTTLE: begin
        if (long_form) begin
          err          = hi ^ lo ^ cmd;
          frame.bytes  = {hi, lo, cmd, err};
          frame.nbytes = 3'd4;
        end else begin
          err          = lo ^ cmd;
          frame.bytes  = {lo, cmd, err, 8'd0};
          frame.nbytes = 3'd3;
        end
      end
      REQ_IDLE: begin
        frame.bytes  = {BYTE_ONES, 8'd0, BYTE_ONES, 8'd0};
        frame.nbytes = 3'd3;
      end
      REQ_RESET, REQ_UNUSED: begin
        frame.bytes  = 32'd0;
        frame.nbytes = 3'd3;
      end
    endcase
  end

endmodule

@@ rtl/dcc_pf_seq.sv @@
`timescale 1ns / 1ps

module dcc_pf_seq
  import dcc_pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dcc_cfg_t   cfg,
  input  dcc_frame_t frame,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dcc_sym_t   out_data
);

  dcc_state_t  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  clo_r, clo_nxt;
  logic [31:0] shreg_r, shreg_nxt;
  logic        out_valid_r, out_valid_nxt;
  dcc_sym_t    out_r, out_nxt;

  logic        adv;
  logic        accept;
  logic        sym;
  logic        last;
  logic [4:0]  pre_sat;
  logic [2:0]  clo_sat;

  always_comb begin
    pre_sat = cfg.preamble_bits;
    if (pre_sat < PRE_MIN) pre_sat = PRE_MIN;
    if (pre_sat > PRE_MAX) pre_sat = PRE_MAX;
    clo_sat = cfg.closer_bits;
    if (clo_sat < CLOSE_MIN) clo_sat = CLOSE_MIN;
    if (clo_sat > CLOSE_MAX) clo_sat = CLOSE_MAX;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    left_nxt      = left_r;
    clo_nxt       = clo_r;
    shreg_nxt     = shreg_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    sym           = 1'b1;
    last          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (adv) out_valid_nxt = 1'b0;
        if (accept && frame.emit) begin
          state_nxt   = ST_PRE;
          cnt_nxt     = pre_sat;
          clo_nxt     = clo_sat;
          shreg_nxt   = frame.bytes;
          left_nxt    = frame.nbytes;
          bit_cnt_nxt = 4'd0;
        end
      end
      ST_PRE: begin
        sym = 1'b1;
        if (adv) begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == 5'd1) state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        // start bit first, then the byte MSB first
        sym = (bit_cnt_r == 4'd0) ? 1'b0 : shreg_r[31];
        if (adv) begin
          if (bit_cnt_r != 4'd0) shreg_nxt = {shreg_r[30:0], 1'b0};
          if (bit_cnt_r == 4'd8) begin
            bit_cnt_nxt = 4'd0;
            left_nxt    = left_r - 3'd1;
            if (left_r == 3'd1) begin
              state_nxt = ST_CLOSE;
              cnt_nxt   = {2'b00, clo_r};
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
          end
        end
      end
      ST_CLOSE: begin
        sym  = 1'b1;
        last = (cnt_r == 5'd1);
        if (adv) begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == 5'd1) state_nxt = ST_IDLE;
        end
      end
    endcase

    if (adv && state_r != ST_IDLE) begin
      out_valid_nxt     = 1'b1;
      out_nxt.bit_value = sym;
      out_nxt.period    = sym ? cfg.one_period : cfg.zero_period;
      out_nxt.last      = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    left_r    <= left_nxt;
    clo_r     <= clo_nxt;
    shreg_r   <= shreg_nxt;
    out_r     <= out_nxt;
  end

endmodule

@@ rtl/dcc_packet_framer_core.sv @@
`timescale 1ns / 1ps

// DCC packet framer.
// Input channel (in_valid/in_ready/in_data): one command per transfer, a
// throttle request, an idle packet or a reset packet. Output channel
// (out_valid/out_ready/out_data): one track-bit symbol per transfer with its
// configured period; last marks the final closer bit of a packet.
// Registers are to be written over the APB port only while no packet is in
// flight (psel/penable/pwrite/paddr/pwdata); the block itself does not
// enforce this. The command is registered into the sequencer state, and the
// first symbol then into the output register. A packet is a preamble
// (10..20) + 9 per byte (3 or 4 bytes) + closer (1..4) symbols, so 38 to
// 60 symbols; a single shift register and bit counter step through the
// packet. in_ready is high only between packets. With track power off, or an
// unused request code, the command is taken and no symbol is sent. A stalled
// receiver holds the current symbol in the output register and freezes the
// sequencer. Reset returns the registers to their defaults, with track
// power off, and drops any packet in progress.
module dcc_packet_framer_core
  import dcc_pf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcc_req_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dcc_sym_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  dcc_cfg_t   cfg;
  dcc_frame_t frame;

  dcc_pf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcc_pf_bytes u_bytes (
    .req         (in_data),
    .track_power (cfg.track_power),
    .frame       (frame)
  );

  dcc_pf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .frame     (frame),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
